// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the contact tracker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent in a cycle implies the consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Antecedent implies a delayed consequent.
`define ASSERT_AFTER2(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##2 (cons)) \
      else $error("assertion failed: two-cycle implication");

`endif

// ----- rtl/core/aabb_pkg.sv -----
// Shared types and constants of the AABB pair contact tracker.
package aabb_pkg;

   localparam int SIZE_BITS  = 15;
   localparam int LAYER_BITS = 3;
   localparam int MASK_BITS  = 64;
   localparam int BIT_BITS   = 6;

   typedef enum logic [1:0] {
      EV_NONE  = 2'd0,
      EV_ENTER = 2'd1,
      EV_STAY  = 2'd2,
      EV_EXIT  = 2'd3
   } event_type;

endpackage

// ----- rtl/core/aabb_axis.sv -----
// Strict overlap test of two boxes along one axis.
module aabb_axis
   import aabb_pkg::*;
#(
   parameter int COORD_BITS = 16
) (
   input  logic signed [COORD_BITS-1:0] pos_left,
   input  logic        [SIZE_BITS-1:0]  size_left,
   input  logic signed [COORD_BITS-1:0] pos_right,
   input  logic        [SIZE_BITS-1:0]  size_right,
   output logic                         hit
);

   localparam int BASE_BITS = (COORD_BITS > SIZE_BITS) ? COORD_BITS + 1 : SIZE_BITS + 1;
   localparam int DW        = BASE_BITS + 2;

   logic signed [DW-1:0] pl_ext;
   logic signed [DW-1:0] pr_ext;
   logic signed [DW-1:0] wl_ext;
   logic signed [DW-1:0] wr_ext;
   logic signed [DW-1:0] diff;
   logic signed [DW-1:0] mag;
   logic signed [DW-1:0] span;

   assign pl_ext = DW'(pos_left);
   assign pr_ext = DW'(pos_right);
   assign wl_ext = signed'(DW'(size_left));
   assign wr_ext = signed'(DW'(size_right));

   // Compare doubled centers against the summed sizes to stay in integers.
   assign diff = (pl_ext <<< 1) + wl_ext - (pr_ext <<< 1) - wr_ext;
   assign mag  = (diff < 0) ? -diff : diff;
   assign span = wl_ext + wr_ext;
   assign hit  = (mag < span);

endmodule

// ----- rtl/core/aabb_flags.sv -----
// Contact bit memory with a clearing pass after reset.
`include "assert_macros.svh"

module aabb_flags
   import aabb_pkg::*;
#(
   parameter int ID_BITS = 5
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 rd_en,
   input  logic [2*ID_BITS-1:0] rd_addr,
   output logic                 rd_data,
   input  logic                 wr_en,
   input  logic [2*ID_BITS-1:0] wr_addr,
   input  logic                 wr_data,
   output logic                 clearing
);

   localparam int AW    = 2 * ID_BITS;
   localparam int DEPTH = 1 << AW;

   logic            flag_mem [DEPTH];
   logic            rd_data_ff;
   logic            clr_active_ff;
   logic            clr_active_in;
   logic [AW-1:0]   clr_addr_ff;
   logic [AW-1:0]   clr_addr_in;
   logic            mem_we;
   logic [AW-1:0]   mem_waddr;
   logic            mem_wdata;

   always_comb begin
      clr_active_in = clr_active_ff;
      clr_addr_in   = clr_addr_ff;
      if (clr_active_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == {AW{1'b1}}) begin
            clr_active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
      end else begin
         clr_active_ff <= clr_active_in;
         clr_addr_ff   <= clr_addr_in;
      end
   end

   assign mem_we    = clr_active_ff | wr_en;
   assign mem_waddr = clr_active_ff ? clr_addr_ff : wr_addr;
   assign mem_wdata = clr_active_ff ? 1'b0 : wr_data;

   // Read returns the value held before a write in the same cycle.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= flag_mem[rd_addr];
      end
      if (mem_we) begin
         flag_mem[mem_waddr] <= mem_wdata;
      end
   end

   assign rd_data  = rd_data_ff;
   assign clearing = clr_active_ff;

   `ASSERT_IMPLIES(a_no_write_while_clearing, clock, reset, clr_active_ff, !wr_en && !rd_en)

endmodule

// ----- rtl/core/aabb_pair_contact_tracker.sv -----
// Top level of the AABB pair contact tracker.
//
//   channel  | ports                         | handshake
//   ---------+-------------------------------+-----------------------------------
//   request  | start, busy, req_*            | beat taken when start && !busy
//   response | rsp_valid, rsp_*              | one-cycle strobe, cannot stall
//   csr      | csr_wr_en, csr_wr_data        | written when csr_wr_en is high
//
// One pair is taken every cycle while busy is low; its result is registered in s1, then in rsp.
// The contact bit memory is read when the beat is taken and written in the next
// cycle; a pair that hits the bit written by the one just before it is forwarded.
// After reset a clearing pass zeroes all 2**(2*ID_BITS) entries (1024 by default) with
// busy high; csr writes are taken during it.
`include "assert_macros.svh"

module aabb_pair_contact_tracker
   import aabb_pkg::*;
#(
   parameter int LAYERS     = 8,
   parameter int ID_BITS    = 5,
   parameter int COORD_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [LAYER_BITS-1:0]        req_left_layer,
   input  logic [LAYER_BITS-1:0]        req_right_layer,
   input  logic [ID_BITS-1:0]           req_left_id,
   input  logic [ID_BITS-1:0]           req_right_id,
   input  logic signed [COORD_BITS-1:0] req_left_x,
   input  logic signed [COORD_BITS-1:0] req_left_y,
   input  logic [SIZE_BITS-1:0]         req_left_w,
   input  logic [SIZE_BITS-1:0]         req_left_h,
   input  logic signed [COORD_BITS-1:0] req_right_x,
   input  logic signed [COORD_BITS-1:0] req_right_y,
   input  logic [SIZE_BITS-1:0]         req_right_w,
   input  logic [SIZE_BITS-1:0]         req_right_h,
   output logic                         rsp_valid,
   output logic [1:0]                   rsp_event_res,
   output logic                         rsp_overlap,
   output logic                         rsp_checked,
   input  logic                         csr_wr_en,
   input  logic [MASK_BITS-1:0]         csr_wr_data
);

   localparam int AW = 2 * ID_BITS;

   logic                         accept;
   logic                         clearing;
   logic [MASK_BITS-1:0]         layer_mask_ff;

   logic                         s1_valid_ff;
   logic [LAYER_BITS-1:0]        s1_left_layer_ff;
   logic [LAYER_BITS-1:0]        s1_right_layer_ff;
   logic [ID_BITS-1:0]           s1_left_id_ff;
   logic [ID_BITS-1:0]           s1_right_id_ff;
   logic signed [COORD_BITS-1:0] s1_left_x_ff;
   logic signed [COORD_BITS-1:0] s1_left_y_ff;
   logic [SIZE_BITS-1:0]         s1_left_w_ff;
   logic [SIZE_BITS-1:0]         s1_left_h_ff;
   logic signed [COORD_BITS-1:0] s1_right_x_ff;
   logic signed [COORD_BITS-1:0] s1_right_y_ff;
   logic [SIZE_BITS-1:0]         s1_right_w_ff;
   logic [SIZE_BITS-1:0]         s1_right_h_ff;
   logic                         fwd_ff;
   logic                         fwd_val_ff;

   logic [AW-1:0]                req_idx;
   logic [AW-1:0]                s1_idx;
   logic                         hit_x;
   logic                         hit_y;
   logic                         s1_hit;
   logic                         layers_ok;
   logic [BIT_BITS-1:0]          mask_bit;
   logic                         s1_chk;
   logic                         s1_write;
   logic                         mem_rd;
   logic                         old_flag;
   event_type                    s1_event;

   logic                         rsp_valid_ff;
   event_type                    rsp_event_ff;
   logic                         rsp_overlap_ff;
   logic                         rsp_checked_ff;

   assign busy    = clearing;
   assign accept  = start & ~clearing;
   assign req_idx = {req_left_id, req_right_id};
   assign s1_idx  = {s1_left_id_ff, s1_right_id_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         layer_mask_ff <= '0;
      end else if (csr_wr_en) begin
         layer_mask_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_left_layer_ff  <= req_left_layer;
         s1_right_layer_ff <= req_right_layer;
         s1_left_id_ff     <= req_left_id;
         s1_right_id_ff    <= req_right_id;
         s1_left_x_ff      <= req_left_x;
         s1_left_y_ff      <= req_left_y;
         s1_left_w_ff      <= req_left_w;
         s1_left_h_ff      <= req_left_h;
         s1_right_x_ff     <= req_right_x;
         s1_right_y_ff     <= req_right_y;
         s1_right_w_ff     <= req_right_w;
         s1_right_h_ff     <= req_right_h;
         // The pair ahead writes its bit at this same edge; catch it here.
         fwd_ff            <= s1_write && (s1_idx == req_idx);
         fwd_val_ff        <= s1_hit;
      end
   end

   aabb_axis #(
      .COORD_BITS (COORD_BITS)
   ) u_axis_x (
      .pos_left   (s1_left_x_ff),
      .size_left  (s1_left_w_ff),
      .pos_right  (s1_right_x_ff),
      .size_right (s1_right_w_ff),
      .hit        (hit_x)
   );

   aabb_axis #(
      .COORD_BITS (COORD_BITS)
   ) u_axis_y (
      .pos_left   (s1_left_y_ff),
      .size_left  (s1_left_h_ff),
      .pos_right  (s1_right_y_ff),
      .size_right (s1_right_h_ff),
      .hit        (hit_y)
   );

   assign s1_hit    = hit_x & hit_y;
   assign layers_ok = (32'(s1_left_layer_ff) < LAYERS) && (32'(s1_right_layer_ff) < LAYERS);
   assign mask_bit  = BIT_BITS'(s1_left_layer_ff) * BIT_BITS'(LAYERS)
                      + BIT_BITS'(s1_right_layer_ff);
   assign s1_chk    = layers_ok && (s1_left_id_ff != s1_right_id_ff)
                      && layer_mask_ff[mask_bit];
   assign s1_write  = s1_valid_ff & s1_chk;
   assign mem_rd    = accept;

   aabb_flags #(
      .ID_BITS (ID_BITS)
   ) u_flags (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (mem_rd),
      .rd_addr  (req_idx),
      .rd_data  (old_flag),
      .wr_en    (s1_write),
      .wr_addr  (s1_idx),
      .wr_data  (s1_hit),
      .clearing (clearing)
   );

   always_comb begin
      logic prev;
      prev     = fwd_ff ? fwd_val_ff : old_flag;
      s1_event = EV_NONE;
      if (s1_chk) begin
         if (s1_hit) begin
            s1_event = prev ? EV_STAY : EV_ENTER;
         end else if (prev) begin
            s1_event = EV_EXIT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_event_ff   <= s1_event;
      rsp_overlap_ff <= s1_hit;
      rsp_checked_ff <= s1_chk;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_event_res = rsp_event_ff;
   assign rsp_overlap   = rsp_overlap_ff;
   assign rsp_checked   = rsp_checked_ff;

   `ASSERT_AFTER2(a_result_follows_beat, clock, reset, accept, rsp_valid)
   `ASSERT_IMPLIES(a_event_needs_check, clock, reset,
                   rsp_valid && (rsp_event_ff != EV_NONE), rsp_checked)
   `ASSERT_IMPLIES(a_contact_needs_overlap, clock, reset,
                   rsp_valid && (rsp_event_ff == EV_ENTER || rsp_event_ff == EV_STAY),
                   rsp_overlap)
   `ASSERT_IMPLIES(a_exit_without_overlap, clock, reset,
                   rsp_valid && (rsp_event_ff == EV_EXIT), !rsp_overlap)

endmodule

// ----- bench/tb_aabb_pair_contact_tracker.sv -----
// Self-checking testbench for the AABB pair contact tracker with a built-in contact predictor.
`timescale 1ns / 100ps

module tb_aabb_pair_contact_tracker
   import aabb_pkg::*;
;
   localparam int ID_W        = 5;
   localparam int COORD_W     = 16;
   localparam int LAYER_COUNT = 8;
   localparam int TABLE_DEPTH = 1 << (2 * ID_W);

   typedef struct packed {
      logic [LAYER_BITS-1:0]     left_layer;
      logic [LAYER_BITS-1:0]     right_layer;
      logic [ID_W-1:0]           left_id;
      logic [ID_W-1:0]           right_id;
      logic signed [COORD_W-1:0] left_x;
      logic signed [COORD_W-1:0] left_y;
      logic [SIZE_BITS-1:0]      left_w;
      logic [SIZE_BITS-1:0]      left_h;
      logic signed [COORD_W-1:0] right_x;
      logic signed [COORD_W-1:0] right_y;
      logic [SIZE_BITS-1:0]      right_w;
      logic [SIZE_BITS-1:0]      right_h;
   } collider_pair_type;

   typedef struct packed {
      event_type ev;
      logic      overlap;
      logic      checked;
   } contact_result_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         start = 1'b0;
   logic                         busy;
   logic [LAYER_BITS-1:0]        req_left_layer = '0;
   logic [LAYER_BITS-1:0]        req_right_layer = '0;
   logic [ID_W-1:0]              req_left_id = '0;
   logic [ID_W-1:0]              req_right_id = '0;
   logic signed [COORD_W-1:0]    req_left_x = '0;
   logic signed [COORD_W-1:0]    req_left_y = '0;
   logic [SIZE_BITS-1:0]         req_left_w = '0;
   logic [SIZE_BITS-1:0]         req_left_h = '0;
   logic signed [COORD_W-1:0]    req_right_x = '0;
   logic signed [COORD_W-1:0]    req_right_y = '0;
   logic [SIZE_BITS-1:0]         req_right_w = '0;
   logic [SIZE_BITS-1:0]         req_right_h = '0;
   logic                         rsp_valid;
   logic [1:0]                   rsp_event_res;
   logic                         rsp_overlap;
   logic                         rsp_checked;
   logic                         csr_wr_en = 1'b0;
   logic [MASK_BITS-1:0]         csr_wr_data = '0;

   // Predictor state: the layer mask as last written and one contact bit per ordered ID pair.
   logic [MASK_BITS-1:0] layer_mask_model = '0;
   bit                   contact_table [TABLE_DEPTH];

   collider_pair_type  pairs_to_send [$];
   contact_result_type awaited_results [$];
   collider_pair_type  pair_on_port = '0;

   int pairs_queued   = 0;
   int pairs_accepted = 0;
   int burst_left     = 0;
   int gap_left       = 0;
   int mismatches     = 0;
   int mask_writes    = 0;
   int enters_seen    = 0;
   int stays_seen     = 0;
   int exits_seen     = 0;
   int skips_seen     = 0;

   aabb_pair_contact_tracker #(
      .LAYERS     (LAYER_COUNT),
      .ID_BITS    (ID_W),
      .COORD_BITS (COORD_W)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_left_layer  (req_left_layer),
      .req_right_layer (req_right_layer),
      .req_left_id     (req_left_id),
      .req_right_id    (req_right_id),
      .req_left_x      (req_left_x),
      .req_left_y      (req_left_y),
      .req_left_w      (req_left_w),
      .req_left_h      (req_left_h),
      .req_right_x     (req_right_x),
      .req_right_y     (req_right_y),
      .req_right_w     (req_right_w),
      .req_right_h     (req_right_h),
      .rsp_valid       (rsp_valid),
      .rsp_event_res   (rsp_event_res),
      .rsp_overlap     (rsp_overlap),
      .rsp_checked     (rsp_checked),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Doubling both sides keeps the center test in integers: |2xl+wl-2xr-wr| < wl+wr.
   function automatic bit axis_overlaps(input logic signed [COORD_W-1:0] pos_l,
                                        input logic [SIZE_BITS-1:0] size_l,
                                        input logic signed [COORD_W-1:0] pos_r,
                                        input logic [SIZE_BITS-1:0] size_r);
      int pl, pr, sl, sr, span;
      pl = int'(pos_l);
      pr = int'(pos_r);
      sl = int'(size_l);
      sr = int'(size_r);
      span = 2 * pl + sl - 2 * pr - sr;
      if (span < 0) span = -span;
      return span < sl + sr;
   endfunction

   function automatic contact_result_type track_contact(input collider_pair_type p);
      contact_result_type r;
      int                 slot;
      r.overlap = axis_overlaps(p.left_x, p.left_w, p.right_x, p.right_w) &&
                  axis_overlaps(p.left_y, p.left_h, p.right_y, p.right_h);
      r.checked = (p.left_id != p.right_id) &&
                  layer_mask_model[int'(p.left_layer) * LAYER_COUNT + int'(p.right_layer)];
      r.ev = EV_NONE;
      slot = int'({p.left_id, p.right_id});
      if (r.checked) begin
         if (r.overlap) begin
            r.ev = contact_table[slot] ? EV_STAY : EV_ENTER;
            contact_table[slot] = 1'b1;
         end else if (contact_table[slot]) begin
            r.ev = EV_EXIT;
            contact_table[slot] = 1'b0;
         end
      end
      return r;
   endfunction

   function automatic collider_pair_type box_pair(input int ll, input int rl, input int lid,
                                                  input int rid, input int lx, input int ly,
                                                  input int lw, input int lh, input int rx,
                                                  input int ry, input int rw, input int rh);
      collider_pair_type p;
      p.left_layer  = LAYER_BITS'(ll);
      p.right_layer = LAYER_BITS'(rl);
      p.left_id     = ID_W'(lid);
      p.right_id    = ID_W'(rid);
      p.left_x      = COORD_W'(lx);
      p.left_y      = COORD_W'(ly);
      p.left_w      = SIZE_BITS'(lw);
      p.left_h      = SIZE_BITS'(lh);
      p.right_x     = COORD_W'(rx);
      p.right_y     = COORD_W'(ry);
      p.right_w     = SIZE_BITS'(rw);
      p.right_h     = SIZE_BITS'(rh);
      return p;
   endfunction

   // Mostly a few IDs with nearby small boxes so that contacts enter, stay and exit;
   // the rest is noise over the full range of every field.
   function automatic collider_pair_type random_pair();
      logic [159:0] noise;
      int           cx, cy;
      if ($urandom_range(0, 4) == 0) begin
         noise = {$urandom, $urandom, $urandom, $urandom, $urandom};
         return noise[$bits(collider_pair_type)-1:0];
      end
      cx = int'($urandom_range(0, 4000)) - 2000;
      cy = int'($urandom_range(0, 4000)) - 2000;
      return box_pair($urandom_range(0, 7), $urandom_range(0, 7),
                      $urandom_range(0, 3), $urandom_range(0, 3),
                      cx, cy, $urandom_range(0, 40), $urandom_range(0, 40),
                      cx + int'($urandom_range(0, 80)) - 40,
                      cy + int'($urandom_range(0, 80)) - 40,
                      $urandom_range(0, 40), $urandom_range(0, 40));
   endfunction

   task automatic queue_pair(input collider_pair_type p);
      pairs_to_send.push_back(p);
      pairs_queued++;
   endtask

   task automatic write_layer_mask(input logic [MASK_BITS-1:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en        <= 1'b0;
      layer_mask_model = value;
      mask_writes++;
   endtask

   // Waits until every queued pair is taken and its result has come back.
   task automatic settle();
      int spins;
      spins = 0;
      while (pairs_accepted != pairs_queued) @(posedge clock);
      while (awaited_results.size() != 0 && spins < 50) begin
         @(posedge clock);
         spins++;
      end
      if (awaited_results.size() != 0) begin
         $error("%0d expected results never arrived", awaited_results.size());
         mismatches++;
         awaited_results.delete();
      end
   endtask

   // Sender: bursts of random length separated by random gaps, sometimes long runs
   // with no gap at all.
   always @(posedge clock) begin : drive_pairs
      logic next_start;
      if (reset) begin
         start <= 1'b0;
      end else begin
         next_start = start;
         if (start && !busy) begin
            awaited_results.push_back(track_contact(pair_on_port));
            pairs_accepted++;
            next_start = 1'b0;
         end
         if (!next_start) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pairs_to_send.size() > 0) begin
               pair_on_port = pairs_to_send.pop_front();
               req_left_layer  <= pair_on_port.left_layer;
               req_right_layer <= pair_on_port.right_layer;
               req_left_id     <= pair_on_port.left_id;
               req_right_id    <= pair_on_port.right_id;
               req_left_x      <= pair_on_port.left_x;
               req_left_y      <= pair_on_port.left_y;
               req_left_w      <= pair_on_port.left_w;
               req_left_h      <= pair_on_port.left_h;
               req_right_x     <= pair_on_port.right_x;
               req_right_y     <= pair_on_port.right_y;
               req_right_w     <= pair_on_port.right_w;
               req_right_h     <= pair_on_port.right_h;
               next_start = 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else if ($urandom_range(0, 3) == 0) begin
                  burst_left = $urandom_range(30, 60);
                  gap_left   = 0;
               end else begin
                  burst_left = $urandom_range(0, 12);
                  gap_left   = $urandom_range(1, 7);
               end
            end
         end
         start <= next_start;
      end
   end

   // Every result beat is compared with the oldest prediction.
   always @(posedge clock) begin : check_results
      contact_result_type want;
      if (!reset && rsp_valid) begin
         if (awaited_results.size() == 0) begin
            $error("result beat with no expectation waiting");
            mismatches++;
         end else begin
            want = awaited_results.pop_front();
            if (rsp_event_res !== want.ev) begin
               $error("event_res: expected %0d, got %0d", want.ev, rsp_event_res);
               mismatches++;
            end
            if (rsp_overlap !== want.overlap) begin
               $error("overlap: expected %0d, got %0d", want.overlap, rsp_overlap);
               mismatches++;
            end
            if (rsp_checked !== want.checked) begin
               $error("checked: expected %0d, got %0d", want.checked, rsp_checked);
               mismatches++;
            end
            case (want.ev)
               EV_ENTER: enters_seen++;
               EV_STAY:  stays_seen++;
               EV_EXIT:  exits_seen++;
               default:  if (!want.checked) skips_seen++;
            endcase
         end
      end
   end

   initial begin : run_phases
      logic [MASK_BITS-1:0] triangle;
      triangle = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // The reset mask skips every pair; these wait out the clearing pass.
      repeat (8) queue_pair(random_pair());
      settle();

      write_layer_mask('1);
      // Enter, stay, exit, then a checked miss with no contact.
      queue_pair(box_pair(1, 2, 1, 2, 0, 0, 10, 10, 5, 5, 10, 10));
      queue_pair(box_pair(1, 2, 1, 2, 0, 0, 10, 10, 5, 5, 10, 10));
      queue_pair(box_pair(1, 2, 1, 2, 0, 0, 10, 10, 20, 0, 10, 10));
      queue_pair(box_pair(1, 2, 1, 2, 0, 0, 10, 10, 20, 0, 10, 10));
      // Equal IDs are skipped while the box test is still reported.
      queue_pair(box_pair(3, 3, 7, 7, 0, 0, 10, 10, 0, 0, 10, 10));
      // The swapped ID order keeps a contact bit of its own.
      queue_pair(box_pair(2, 1, 2, 1, 0, 0, 10, 10, 5, 5, 10, 10));
      queue_pair(box_pair(1, 2, 1, 2, 0, 0, 10, 10, 5, 5, 10, 10));
      queue_pair(box_pair(2, 1, 2, 1, 0, 0, 10, 10, 5, 5, 10, 10));
      // Edges that only touch do not overlap; one pixel of overlap does.
      queue_pair(box_pair(0, 0, 4, 5, 0, 0, 10, 10, 10, 0, 5, 10));
      queue_pair(box_pair(0, 0, 4, 5, 0, 0, 10, 10, 0, 10, 10, 5));
      queue_pair(box_pair(0, 0, 4, 5, 0, 0, 10, 10, 9, 9, 5, 5));
      // Zero-size boxes inside the other box still overlap; two zero-size boxes never do.
      queue_pair(box_pair(0, 0, 4, 5, 3, 3, 0, 4, 0, 0, 10, 10));
      queue_pair(box_pair(0, 0, 4, 5, 3, 3, 4, 0, 0, 0, 10, 10));
      queue_pair(box_pair(0, 0, 4, 5, 3, 3, 0, 0, 3, 3, 0, 0));
      // Field extremes.
      queue_pair(box_pair(7, 0, 31, 0, -32768, -32768, 32767, 32767,
                          -32768, -32768, 32767, 32767));
      queue_pair(box_pair(0, 7, 0, 31, 32767, 32767, 32767, 32767,
                          32767, 32767, 32767, 32767));
      queue_pair(box_pair(7, 7, 31, 30, -32768, -32768, 32767, 32767,
                          32767, 32767, 32767, 32767));
      queue_pair(box_pair(7, 0, 31, 0, 32767, -32768, 1, 1, -32768, 32767, 1, 1));
      queue_pair(box_pair(7, 0, 31, 0, -1, -1, 2, 2, 0, 0, 1, 1));
      repeat (150) queue_pair(random_pair());
      settle();

      // Only the row <= col half of the mask.
      for (int r = 0; r < LAYER_COUNT; r++)
         for (int c = r; c < LAYER_COUNT; c++)
            triangle[r * LAYER_COUNT + c] = 1'b1;
      write_layer_mask(triangle);
      repeat (110) queue_pair(random_pair());
      settle();

      write_layer_mask({$urandom, $urandom});
      repeat (80) queue_pair(random_pair());
      settle();

      write_layer_mask('0);
      repeat (15) queue_pair(random_pair());
      settle();

      // Contacts left over from earlier settings now exit or stay.
      write_layer_mask('1);
      repeat (40) queue_pair(random_pair());
      settle();

      repeat (4) @(posedge clock);
      $display("Covered %0d pairs under %0d mask settings: %0d enter, %0d stay, %0d exit.",
               pairs_accepted, mask_writes + 1, enters_seen, stays_seen, exits_seen);
      $display("%0d pairs were skipped by layer mask or equal IDs; %0d mismatches.",
               skips_seen, mismatches);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin : watchdog
      #2000000;
      $display("Timed out with %0d of %0d pairs taken.", pairs_accepted, pairs_queued);
      $display("FAIL");
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/aabb_pkg.sv
rtl/core/aabb_axis.sv
rtl/core/aabb_flags.sv
rtl/core/aabb_pair_contact_tracker.sv
bench/tb_aabb_pair_contact_tracker.sv
